// ----- rtl/sfla_pkg.sv -----
// Shared types and constants for the segregated free-list allocator.
// Holds word field widths, operation and status codes, and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package sfla_pkg;

  localparam int REQUEST_BYTES_W = 16;
  localparam int ADDRESS_W       = 20;
  localparam int USED_BYTES_W    = 21;
  localparam int STATUS_W        = 3;
  localparam int LIMIT_W         = 21;

  // Block index carried by a 20-bit byte offset of an 8-byte aligned block.
  localparam int BLK_W           = ADDRESS_W - 3;
  // Rounded size and carve size both fit in 17 bits (at most 65536).
  localparam int SIZE_EXT_W      = 17;
  // Class number before range check (at most 56).
  localparam int CLS_FULL_W      = 6;

  localparam int LIMIT_RESET     = 1048576;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BUMP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FREED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd4;

  typedef struct packed {
    logic                       op;
    logic [REQUEST_BYTES_W-1:0] request_bytes;
    logic [ADDRESS_W-1:0]       block_address;
  } sfla_req_t;

  typedef struct packed {
    logic [ADDRESS_W-1:0]    address;
    logic [STATUS_W-1:0]     status;
    logic [USED_BYTES_W-1:0] used_bytes;
  } sfla_rsp_t;

  typedef struct packed {
    logic capture;
    logic link_read;
    logic finish_exec;
    logic finish_pop;
  } sfla_cmd_t;

  typedef struct packed {
    logic need_pop;
  } sfla_stat_t;

endpackage

// ----- rtl/segregated_free_list_allocator.sv -----
// Top level of the segregated free-list allocator.
// Joins the controller (sfla_ctrl) and the datapath (sfla_datapath).
// Depends on sfla_pkg.
`timescale 1ns / 1ps
//
//   Channel   Direction  Handshake            Word
//   --------  ---------  -------------------  --------------------------------
//   in        input      in_valid/in_ready    op, request_bytes, block_address
//   out       output     out_valid/out_ready  address, status, used_bytes
//   cfg       input      cfg_we               cfg_wdata (heap limit, bytes)
//
// An allocate that finds a free block on its class list reads the class head
// when it is accepted, then reads the link store for the next block, then
// writes the head back. Every other word (bump allocate, free, too large,
// out of space) skips the link store read.
// Reset is synchronous; it empties all class lists through their valid bits,
// zeroes the bump pointer and loads the heap limit. The link store is not
// cleared, so the block is ready in the cycle after reset.
// A result waits in the output register until taken; a finished word behind
// it holds in the controller, and the input stays stalled meanwhile.

module segregated_free_list_allocator import sfla_pkg::*; #(
  parameter int HEAP_BYTES      = 1048576,
  parameter int NUM_CLASSES     = 44,
  parameter int MAX_BLOCK_BYTES = 7168
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  sfla_req_t          in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output sfla_rsp_t          out_word
);

  sfla_cmd_t  cmd;
  sfla_stat_t stat;

  // The controller decides when a word is captured, when the link store is
  // read for a pop, and when the result is committed to the output register.
  sfla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds all allocator state and forms the result word.
  sfla_datapath #(
    .HEAP_BYTES      (HEAP_BYTES),
    .NUM_CLASSES     (NUM_CLASSES),
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_word  (out_word)
  );

  // Only allocations that succeed carry a nonzero address.
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.status == ST_FREED || out_word.status == ST_TOO_LARGE ||
                  out_word.status == ST_NO_SPACE) |-> out_word.address == '0)
    else $error("address nonzero for a word that allocated nothing");

  // One word at a time: an accept is never followed directly by another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is still in progress");

  // A committed result is always one of the defined status codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.status <= ST_NO_SPACE)
    else $error("undefined status code on the output");

endmodule

// ----- rtl/sfla_decode.sv -----
// Size decoder: rounds a request to 8 bytes, finds its size class and
// the number of bytes a bump allocation carves for it.
// Depends on sfla_pkg.
`timescale 1ns / 1ps

module sfla_decode import sfla_pkg::*; #(
  parameter int NUM_CLASSES     = 44,
  parameter int MAX_BLOCK_BYTES = 7168
) (
  input  logic [REQUEST_BYTES_W-1:0]     request_bytes,
  output logic [$clog2(NUM_CLASSES)-1:0] cls_idx,
  output logic                           too_large,
  output logic [SIZE_EXT_W-1:0]          carve
);

  localparam int CLS_AW = $clog2(NUM_CLASSES);
  localparam int CAP    = ((MAX_BLOCK_BYTES + 7) / 8) * 8;

  logic [SIZE_EXT_W-1:0] esize;
  logic [SIZE_EXT_W-1:0] shifted;
  logic [4:0]            top;
  logic [1:0]            frac;
  logic [CLS_FULL_W-1:0] cls_full;
  logic [17:0]           big;

  assign esize = (SIZE_EXT_W'(request_bytes) + SIZE_EXT_W'(7)) & ~SIZE_EXT_W'(7);

  // Position of the highest set bit.
  always_comb begin
    top = '0;
    for (int i = 0; i < SIZE_EXT_W; i++) begin
      if (esize[i]) begin
        top = 5'(i);
      end
    end
  end

  assign shifted  = esize >> (top - 5'd2);
  assign frac     = shifted[1:0];
  assign cls_full = (esize == '0) ? '0
                  : CLS_FULL_W'({top, 2'b00}) + CLS_FULL_W'(frac) - CLS_FULL_W'(8);
  assign cls_idx  = cls_full[CLS_AW-1:0];

  assign too_large = (32'(request_bytes) > 32'(MAX_BLOCK_BYTES)) ||
                     (32'(cls_full) >= 32'(NUM_CLASSES));

  // Largest rounded size of the class, capped, and never below the request.
  always_comb begin
    if (top < 5'd5) begin
      big = 18'({1'b1, frac}) << (top - 5'd2);
    end else begin
      big = (18'(4'd5 + 4'(frac)) << (top - 5'd2)) - 18'd8;
    end
    if (big > 18'(CAP)) begin
      big = 18'(CAP);
    end
    if (big < 18'(esize)) begin
      big = 18'(esize);
    end
  end

  assign carve = (esize == '0) ? '0 : SIZE_EXT_W'(big);

endmodule

// ----- rtl/sfla_ctrl.sv -----
// Sequencing controller: accepts a word, runs the execute step, the
// optional link store read for a list pop, and hands off to the output
// register. Depends on sfla_pkg.
`timescale 1ns / 1ps

module sfla_ctrl import sfla_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  sfla_stat_t stat,
  output sfla_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       room;

  // The output register can take a new word when empty or being drained.
  assign room     = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.need_pop) begin
          cmd.link_read = 1'b1;
          state_next    = S_POP;
        end else if (room) begin
          cmd.finish_exec = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_POP: begin
        if (room) begin
          cmd.finish_pop = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish_exec || cmd.finish_pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/sfla_datapath.sv -----
// Allocator datapath: size decode, class head store with valid bits,
// per-block link store, bump pointer, heap limit and output register.
// Depends on sfla_pkg and sfla_decode.
`timescale 1ns / 1ps

module sfla_datapath import sfla_pkg::*; #(
  parameter int HEAP_BYTES      = 1048576,
  parameter int NUM_CLASSES     = 44,
  parameter int MAX_BLOCK_BYTES = 7168
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  sfla_req_t          in_word,
  input  sfla_cmd_t          cmd,
  output sfla_stat_t         stat,
  output sfla_rsp_t          out_word
);

  localparam int HEAP_BLOCKS = HEAP_BYTES / 8;
  localparam int IN_BLOCKS   = 2 ** BLK_W;
  localparam int LINK_DEPTH  = (HEAP_BLOCKS < IN_BLOCKS) ? HEAP_BLOCKS : IN_BLOCKS;
  localparam int LINK_AW     = $clog2(LINK_DEPTH);
  localparam int CLS_AW      = $clog2(NUM_CLASSES);
  localparam int PTR_W       = $clog2(HEAP_BYTES + 1);
  localparam int SUM_W       = ((PTR_W > SIZE_EXT_W) ? PTR_W : SIZE_EXT_W) + 1;
  localparam int LIMIT_INIT  = (LIMIT_RESET < HEAP_BYTES) ? LIMIT_RESET : HEAP_BYTES;

  // Decoded request.
  logic [CLS_AW-1:0]     dec_cls;
  logic                  dec_too_large;
  logic [SIZE_EXT_W-1:0] dec_carve;
  logic [CLS_AW-1:0]     rd_cls;

  // Item registers.
  logic                  op_q;
  logic [BLK_W-1:0]      blk_q;
  logic [CLS_AW-1:0]     cls_q;
  logic                  too_large_q;
  logic [SIZE_EXT_W-1:0] carve_q;
  logic [LINK_AW-1:0]    head_idx_q;
  logic                  head_valid_q;
  logic [LINK_AW:0]      link_q;

  // State.
  logic [LINK_AW-1:0]     heads_mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] head_valid;
  logic [LINK_AW:0]       link_mem [LINK_DEPTH];
  logic [PTR_W-1:0]       bump;
  logic [PTR_W-1:0]       bump_next;
  logic [PTR_W-1:0]       limit;

  logic                  blk_in_heap;
  logic [SUM_W-1:0]      bump_sum;
  logic                  bump_fits;
  logic                  do_push;
  sfla_rsp_t             rsp_next;

  sfla_decode #(
    .NUM_CLASSES     (NUM_CLASSES),
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_decode (
    .request_bytes (in_word.request_bytes),
    .cls_idx       (dec_cls),
    .too_large     (dec_too_large),
    .carve         (dec_carve)
  );

  assign rd_cls = dec_too_large ? '0 : dec_cls;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q         <= in_word.op;
      blk_q        <= in_word.block_address[ADDRESS_W-1:3];
      cls_q        <= rd_cls;
      too_large_q  <= dec_too_large;
      carve_q      <= dec_carve;
      head_idx_q   <= heads_mem[rd_cls];
      head_valid_q <= head_valid[rd_cls];
    end
  end

  assign stat.need_pop = !too_large_q && (op_q == OP_ALLOC) && head_valid_q;

  assign blk_in_heap = 32'(blk_q) < 32'(HEAP_BLOCKS);
  assign bump_sum    = SUM_W'(bump) + SUM_W'(carve_q);
  assign bump_fits   = bump_sum <= SUM_W'(limit);

  always_comb begin
    rsp_next            = '0;
    rsp_next.status     = ST_NO_SPACE;
    bump_next           = bump;
    do_push             = 1'b0;
    if (cmd.finish_pop) begin
      rsp_next.address = ADDRESS_W'({head_idx_q, 3'b000});
      rsp_next.status  = ST_REUSED;
    end else begin
      priority if (too_large_q) begin
        rsp_next.status = ST_TOO_LARGE;
      end else if (op_q == OP_FREE) begin
        rsp_next.status = ST_FREED;
        do_push         = blk_in_heap;
      end else if (bump_fits) begin
        rsp_next.address = ADDRESS_W'(bump);
        rsp_next.status  = ST_BUMP;
        bump_next        = PTR_W'(bump_sum);
      end else begin
        rsp_next.status = ST_NO_SPACE;
      end
    end
    rsp_next.used_bytes = USED_BYTES_W'(bump_next);
  end

  // Link store: written by a free, read when a list is popped.
  always_ff @(posedge clk) begin
    if (cmd.finish_exec && do_push) begin
      link_mem[blk_q[LINK_AW-1:0]] <= {head_valid_q, head_idx_q};
    end
    if (cmd.link_read) begin
      link_q <= link_mem[head_idx_q];
    end
  end

  // Class head store.
  always_ff @(posedge clk) begin
    if (cmd.finish_exec && do_push) begin
      heads_mem[cls_q] <= blk_q[LINK_AW-1:0];
    end else if (cmd.finish_pop) begin
      heads_mem[cls_q] <= link_q[LINK_AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_exec || cmd.finish_pop) begin
      out_word <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= '0;
      bump       <= '0;
      limit      <= PTR_W'(LIMIT_INIT);
    end else begin
      if (cfg_we) begin
        if (32'(cfg_wdata) > 32'(HEAP_BYTES)) begin
          limit <= PTR_W'(HEAP_BYTES);
        end else begin
          limit <= PTR_W'(cfg_wdata);
        end
      end
      if (cmd.finish_exec) begin
        bump <= bump_next;
        if (do_push) begin
          head_valid[cls_q] <= 1'b1;
        end
      end else if (cmd.finish_pop) begin
        head_valid[cls_q] <= link_q[LINK_AW];
      end
    end
  end

endmodule
